// ----- src/ese_pkg.sv -----
package ese_pkg;

    localparam int COEFF_FRAC_BITS = 16;
    localparam int CFG_IDX_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_FF    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_FB    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_FF     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_FB     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_RPP   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_RPP    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_METERS_RAD  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 4'd7;

    localparam logic [31:0] RST_MOTOR_RPP   = 32'd13493037;
    localparam logic [31:0] RST_PEND_RPP    = 32'd6746518;
    localparam logic [31:0] RST_METERS_RAD  = 32'd3221225;
    localparam logic [19:0] RST_SAMPLE_RATE = 20'd1000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_DIFF,
        ST_RATE,
        ST_RAW,
        ST_FF,
        ST_Y,
        ST_FB,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] rpp;
        logic [59:0] ff;
        logic [39:0] fb;
        logic [19:0] rate;
    } t_lane_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sd140737488355327) begin
            r = 48'sh7fffffffffff;
        end else if (v < -64'sd140737488355328) begin
            r = 48'sh800000000000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

// ----- src/ese_lane.sv -----
module ese_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ese_pkg::t_state         i_state,
    input  ese_pkg::t_lane_cfg      i_cfg,
    input  logic signed [31:0]      i_count,
    output logic signed [31:0]      o_angle,
    output logic signed [31:0]      o_velocity
);

    logic signed [63:0] w_pa;
    logic signed [31:0] w_x;
    logic signed [34:0] w_x35, w_h0_35, w_h1_35, w_diff;
    logic signed [55:0] w_pr;
    logic signed [19:0] w_b0, w_b1, w_b2, w_a1, w_a2;

    logic signed [63:0] r_pa;
    logic signed [31:0] r_x;
    logic signed [34:0] r_diff;
    logic signed [55:0] r_pr;
    logic signed [31:0] r_raw;
    logic signed [51:0] r_f0, r_f1, r_f2;
    logic signed [31:0] r_y;
    logic signed [51:0] r_g1, r_g2;
    logic signed [31:0] r_h0, r_h1;
    logic signed [47:0] r_d1, r_d2;

    assign w_b0 = $signed(i_cfg.ff[19:0]);
    assign w_b1 = $signed(i_cfg.ff[39:20]);
    assign w_b2 = $signed(i_cfg.ff[59:40]);
    assign w_a1 = $signed(i_cfg.fb[19:0]);
    assign w_a2 = $signed(i_cfg.fb[39:20]);

    assign w_pa    = 64'(i_count) * 64'($signed({1'b0, i_cfg.rpp}));
    assign w_x     = ese_pkg::sat32(r_pa >>> 16);
    assign w_x35   = 35'(w_x);
    assign w_h0_35 = 35'(r_h0);
    assign w_h1_35 = 35'(r_h1);
    assign w_diff  = (w_x35 <<< 1) + w_x35 - (w_h0_35 <<< 2) + w_h1_35;
    assign w_pr    = 56'(r_diff) * 56'($signed({1'b0, i_cfg.rate}));

    always_ff @(posedge i_clk) begin
        case (i_state)
            ese_pkg::ST_ANG: begin
                r_pa <= w_pa;
            end
            ese_pkg::ST_DIFF: begin
                r_x    <= w_x;
                r_diff <= w_diff;
            end
            ese_pkg::ST_RATE: begin
                r_pr <= w_pr;
            end
            ese_pkg::ST_RAW: begin
                r_raw <= ese_pkg::sat32(64'(r_pr >>> 1));
            end
            ese_pkg::ST_FF: begin
                r_f0 <= 52'(w_b0) * 52'(r_raw);
                r_f1 <= 52'(w_b1) * 52'(r_raw);
                r_f2 <= 52'(w_b2) * 52'(r_raw);
            end
            ese_pkg::ST_Y: begin
                r_y <= ese_pkg::sat32(64'(r_f0 >>> ese_pkg::COEFF_FRAC_BITS) + 64'(r_d1));
            end
            ese_pkg::ST_FB: begin
                r_g1 <= 52'(w_a1) * 52'(r_y);
                r_g2 <= 52'(w_a2) * 52'(r_y);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0 <= '0;
            r_h1 <= '0;
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            case (i_state)
                ese_pkg::ST_DIFF: begin
                    r_h1 <= r_h0;
                    r_h0 <= w_x;
                end
                ese_pkg::ST_UPD: begin
                    r_d1 <= ese_pkg::sat48(64'(r_f1 >>> ese_pkg::COEFF_FRAC_BITS)
                                         + 64'(r_g1 >>> ese_pkg::COEFF_FRAC_BITS)
                                         + 64'(r_d2));
                    r_d2 <= ese_pkg::sat48(64'(r_f2 >>> ese_pkg::COEFF_FRAC_BITS)
                                         + 64'(r_g2 >>> ese_pkg::COEFF_FRAC_BITS));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_angle    = r_x;
    assign o_velocity = r_y;

endmodule

// ----- src/ese_merge.sv -----
module ese_merge (
    input  logic                i_clk,
    input  ese_pkg::t_state     i_state,
    input  logic [31:0]         i_meters_per_radian,
    input  logic signed [31:0]  i_motor_theta,
    input  logic signed [31:0]  i_motor_omega,
    output logic signed [31:0]  o_cart_position,
    output logic signed [31:0]  o_cart_speed
);

    logic signed [63:0] r_cp, r_cs;

    always_ff @(posedge i_clk) begin
        if (i_state == ese_pkg::ST_FB) begin
            r_cp <= 64'(i_motor_theta) * 64'($signed({1'b0, i_meters_per_radian}));
            r_cs <= 64'(i_motor_omega) * 64'($signed({1'b0, i_meters_per_radian}));
        end
    end

    assign o_cart_position = ese_pkg::sat32(r_cp >>> 32);
    assign o_cart_speed    = ese_pkg::sat32(r_cs >>> 32);

endmodule

// ----- src/encoder_state_estimator.sv -----
// Encoder state estimator: takes one beat of signed motor and pendulum counts and returns one
// beat of Q16.16 angles, biquad-filtered velocities, cart position and cart speed, all saturated.
// Both channels run in parallel lanes through a fixed sequence of multiply steps (angle scale,
// rate scale, feedforward, feedback) and a merge stage forms the cart terms. The done step loads
// the output register, waiting while the output is stalled; new beats are taken only after that
// load. The output register holds a result while the next sample is processed. Configuration is
// written through the cfg channel, which is always ready; unknown indexes are ignored.
module encoder_state_estimator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [31:0]              i_motor_count,
    input  logic signed [31:0]              i_pendulum_count,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_motor_theta,
    output logic signed [31:0]              o_motor_omega,
    output logic signed [31:0]              o_pendulum_theta,
    output logic signed [31:0]              o_pendulum_omega,
    output logic signed [31:0]              o_cart_position,
    output logic signed [31:0]              o_cart_speed,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ese_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [59:0]                     i_cfg_data
);

    ese_pkg::t_state r_state, n_state;

    logic [59:0] r_motor_ff, r_pend_ff;
    logic [39:0] r_motor_fb, r_pend_fb;
    logic [31:0] r_motor_rpp, r_pend_rpp, r_meters_rad;
    logic [19:0] r_sample_rate;

    logic signed [31:0] r_motor_count, r_pend_count;
    logic               r_out_valid, n_out_valid;
    logic               w_load;

    ese_pkg::t_lane_cfg w_motor_cfg, w_pend_cfg;
    logic signed [31:0] w_ma, w_mv, w_pa, w_pv, w_cp, w_cs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_ff    <= '0;
            r_motor_fb    <= '0;
            r_pend_ff     <= '0;
            r_pend_fb     <= '0;
            r_motor_rpp   <= ese_pkg::RST_MOTOR_RPP;
            r_pend_rpp    <= ese_pkg::RST_PEND_RPP;
            r_meters_rad  <= ese_pkg::RST_METERS_RAD;
            r_sample_rate <= ese_pkg::RST_SAMPLE_RATE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ese_pkg::CFG_MOTOR_FF:    r_motor_ff    <= i_cfg_data;
                ese_pkg::CFG_MOTOR_FB:    r_motor_fb    <= i_cfg_data[39:0];
                ese_pkg::CFG_PEND_FF:     r_pend_ff     <= i_cfg_data;
                ese_pkg::CFG_PEND_FB:     r_pend_fb     <= i_cfg_data[39:0];
                ese_pkg::CFG_MOTOR_RPP:   r_motor_rpp   <= i_cfg_data[31:0];
                ese_pkg::CFG_PEND_RPP:    r_pend_rpp    <= i_cfg_data[31:0];
                ese_pkg::CFG_METERS_RAD:  r_meters_rad  <= i_cfg_data[31:0];
                ese_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != ese_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_motor_count <= i_motor_count;
            r_pend_count  <= i_pendulum_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ese_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        w_load      = 1'b0;
        case (r_state)
            ese_pkg::ST_IDLE: if (i_in_valid) n_state = ese_pkg::ST_ANG;
            ese_pkg::ST_ANG:  n_state = ese_pkg::ST_DIFF;
            ese_pkg::ST_DIFF: n_state = ese_pkg::ST_RATE;
            ese_pkg::ST_RATE: n_state = ese_pkg::ST_RAW;
            ese_pkg::ST_RAW:  n_state = ese_pkg::ST_FF;
            ese_pkg::ST_FF:   n_state = ese_pkg::ST_Y;
            ese_pkg::ST_Y:    n_state = ese_pkg::ST_FB;
            ese_pkg::ST_FB:   n_state = ese_pkg::ST_UPD;
            ese_pkg::ST_UPD:  n_state = ese_pkg::ST_DONE;
            ese_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ese_pkg::ST_IDLE;
                end
            end
            default: n_state = ese_pkg::ST_IDLE;
        endcase
    end

    assign w_motor_cfg = '{rpp: r_motor_rpp, ff: r_motor_ff, fb: r_motor_fb,
                           rate: r_sample_rate};
    assign w_pend_cfg  = '{rpp: r_pend_rpp, ff: r_pend_ff, fb: r_pend_fb,
                           rate: r_sample_rate};

    ese_lane u_motor_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_state    (r_state),
        .i_cfg      (w_motor_cfg),
        .i_count    (r_motor_count),
        .o_angle    (w_ma),
        .o_velocity (w_mv)
    );

    ese_lane u_pend_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_state    (r_state),
        .i_cfg      (w_pend_cfg),
        .i_count    (r_pend_count),
        .o_angle    (w_pa),
        .o_velocity (w_pv)
    );

    ese_merge u_merge (
        .i_clk               (i_clk),
        .i_state             (r_state),
        .i_meters_per_radian (r_meters_rad),
        .i_motor_theta       (w_ma),
        .i_motor_omega       (w_mv),
        .o_cart_position     (w_cp),
        .o_cart_speed        (w_cs)
    );

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_motor_theta    <= w_ma;
            o_motor_omega    <= w_mv;
            o_pendulum_theta <= w_pa;
            o_pendulum_omega <= w_pv;
            o_cart_position  <= w_cp;
            o_cart_speed     <= w_cs;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ese_pkg::ST_ANG))
        else $error("accepted beat did not start the sequence");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ese_pkg::ST_DONE))
        else $error("result appeared outside the done step");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ese_pkg::ST_DONE) && !i_out_stall)
        |=> (o_out_valid && (r_state == ese_pkg::ST_IDLE)))
        else $error("finished result was not loaded");

endmodule
